>>> rtl/chm_pkg.sv
// Shared constants, micro-operation codes, status bundle and home hash
// for the coalesced hash map engine. No dependencies.
package chm_pkg;

  localparam int CAPACITY   = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int LINK_W     = IDX_W + 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam logic [LINK_W-1:0] END_LINK = LINK_W'(CAPACITY);

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [4:0] {
    U_IDLE, U_NOP, U_F_RD, U_F_EN, U_F_KEY, U_L_RD, U_L_VAL, U_S_WR, U_NF,
    U_P_HOME, U_P_FP, U_P_HK, U_P_OTH, U_W_RD, U_W_CHK, U_P_LINK, U_P_MOVE,
    U_P_FILL, U_R_START, U_R_LK, U_R_RD, U_R_CHK, U_R_UNLINK, U_R_COPY,
    U_R_CLEAR, U_RES
  } uop_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       live_zero;
    logic       full;
    logic       cur_ok;
    logic       key_eq;
    logic       h_used;
    logic       fp_stop;
    logic       evict;
    logic       walk_stop;
    logic       gone_is_last;
    logic       ent_is_last;
    logic       pred_valid;
    logic       linkb_valid;
  } dp_stat_t;

  // Fold the key into a bucket index.
  function automatic logic [IDX_W-1:0] home_of(input logic [KEY_BITS-1:0] k);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    return h;
  endfunction

endpackage

>>> rtl/chm_ctrl.sv
// Sequencer for the coalesced hash map engine: steps through the micro-ops
// of one command. Depends on chm_pkg.
module chm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  input  chm_pkg::dp_stat_t stat,
  output logic              in_ready,
  output chm_pkg::uop_t     uop
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_F_RD, S_F_EN, S_F_KEY, S_L_RD, S_L_VAL, S_S_WR, S_NF,
    S_P_HOME, S_P_FP, S_P_HK, S_P_OTH, S_W_RD, S_W_CHK, S_P_LINK, S_P_MOVE,
    S_P_FILL, S_R_START, S_R_LK, S_R_RD, S_R_CHK, S_R_UNLINK, S_R_COPY,
    S_R_CLEAR, S_RES
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        if (!(stat.cmd inside {chm_pkg::CMD_LOOKUP, chm_pkg::CMD_SET,
                               chm_pkg::CMD_REMOVE})) state_nxt = S_RES;
        else if (stat.live_zero) state_nxt = S_NF;
        else state_nxt = S_F_RD;
      end
      S_F_RD:     state_nxt = stat.cur_ok ? S_F_EN : S_NF;
      S_F_EN:     state_nxt = S_F_KEY;
      S_F_KEY: begin
        if (!stat.key_eq) state_nxt = S_F_RD;
        else if (stat.cmd == chm_pkg::CMD_LOOKUP) state_nxt = S_L_RD;
        else if (stat.cmd == chm_pkg::CMD_SET) state_nxt = S_S_WR;
        else state_nxt = S_R_START;
      end
      S_L_RD:     state_nxt = S_L_VAL;
      S_L_VAL:    state_nxt = S_RES;
      S_S_WR:     state_nxt = S_RES;
      S_NF:       state_nxt = (stat.cmd == chm_pkg::CMD_SET && !stat.full) ? S_P_HOME : S_RES;
      S_P_HOME:   state_nxt = stat.h_used ? S_P_FP : S_RES;
      S_P_FP:     if (stat.fp_stop) state_nxt = S_P_HK;
      S_P_HK:     state_nxt = S_P_OTH;
      S_P_OTH:    state_nxt = S_W_RD;
      S_W_RD:     state_nxt = S_W_CHK;
      S_W_CHK:    state_nxt = stat.walk_stop ? S_P_LINK : S_W_RD;
      S_P_LINK:   state_nxt = stat.evict ? S_P_MOVE : S_P_FILL;
      S_P_MOVE:   state_nxt = S_P_FILL;
      S_P_FILL:   state_nxt = S_RES;
      S_R_START:  state_nxt = stat.gone_is_last ? S_R_UNLINK : S_R_LK;
      S_R_LK:     state_nxt = S_R_RD;
      S_R_RD:     state_nxt = S_R_CHK;
      S_R_CHK:    state_nxt = stat.ent_is_last ? S_R_UNLINK : S_R_RD;
      S_R_UNLINK: begin
        if (stat.pred_valid || !stat.linkb_valid) state_nxt = S_R_CLEAR;
        else state_nxt = S_R_COPY;
      end
      S_R_COPY:   state_nxt = S_R_CLEAR;
      S_R_CLEAR:  state_nxt = S_RES;
      S_RES:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    case (state_r)
      S_IDLE:     uop = chm_pkg::U_IDLE;
      S_DISP:     uop = chm_pkg::U_NOP;
      S_F_RD:     uop = chm_pkg::U_F_RD;
      S_F_EN:     uop = chm_pkg::U_F_EN;
      S_F_KEY:    uop = chm_pkg::U_F_KEY;
      S_L_RD:     uop = chm_pkg::U_L_RD;
      S_L_VAL:    uop = chm_pkg::U_L_VAL;
      S_S_WR:     uop = chm_pkg::U_S_WR;
      S_NF:       uop = chm_pkg::U_NF;
      S_P_HOME:   uop = chm_pkg::U_P_HOME;
      S_P_FP:     uop = chm_pkg::U_P_FP;
      S_P_HK:     uop = chm_pkg::U_P_HK;
      S_P_OTH:    uop = chm_pkg::U_P_OTH;
      S_W_RD:     uop = chm_pkg::U_W_RD;
      S_W_CHK:    uop = chm_pkg::U_W_CHK;
      S_P_LINK:   uop = chm_pkg::U_P_LINK;
      S_P_MOVE:   uop = chm_pkg::U_P_MOVE;
      S_P_FILL:   uop = chm_pkg::U_P_FILL;
      S_R_START:  uop = chm_pkg::U_R_START;
      S_R_LK:     uop = chm_pkg::U_R_LK;
      S_R_RD:     uop = chm_pkg::U_R_RD;
      S_R_CHK:    uop = chm_pkg::U_R_CHK;
      S_R_UNLINK: uop = chm_pkg::U_R_UNLINK;
      S_R_COPY:   uop = chm_pkg::U_R_COPY;
      S_R_CLEAR:  uop = chm_pkg::U_R_CLEAR;
      S_RES:      uop = chm_pkg::U_RES;
      default:    uop = chm_pkg::U_NOP;
    endcase
  end

endmodule

>>> rtl/chm_datapath.sv
// Datapath of the coalesced hash map engine: bucket and entry memories,
// occupancy flags, walk pointers and result fields. Depends on chm_pkg.
module chm_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  chm_pkg::uop_t                   uop,
  input  logic                            in_valid,
  input  logic [1:0]                      in_cmd,
  input  logic [chm_pkg::KEY_BITS-1:0]    in_key,
  input  logic [chm_pkg::VALUE_BITS-1:0]  in_value,
  output chm_pkg::dp_stat_t               stat,
  output logic                            res_found,
  output logic [chm_pkg::VALUE_BITS-1:0]  res_value,
  output logic [1:0]                      res_status,
  output logic [chm_pkg::CNT_W-1:0]       res_count
);

  localparam int IW = chm_pkg::IDX_W;
  localparam int LW = chm_pkg::LINK_W;
  localparam int KW = chm_pkg::KEY_BITS;
  localparam int VW = chm_pkg::VALUE_BITS;
  localparam int CW = chm_pkg::CNT_W;

  // Memories
  logic [IW-1:0] bent_mem [chm_pkg::CAPACITY];
  logic [LW-1:0] blink_mem [chm_pkg::CAPACITY];
  logic [KW-1:0] key_mem [chm_pkg::CAPACITY];
  logic [VW-1:0] val_mem [chm_pkg::CAPACITY];

  logic [IW-1:0] ent_rd_r;
  logic [LW-1:0] link_rd_r;
  logic [KW-1:0] key_rd_r;
  logic [VW-1:0] val_rd_r;

  logic          bk_re, be_we, lk_we, k_re, k_we, v_re, v_we;
  logic [IW-1:0] bk_ra, be_wa, lk_wa, k_ra, k_wa, v_ra, v_wa;
  logic [IW-1:0] be_wd;
  logic [LW-1:0] lk_wd;
  logic [KW-1:0] k_wd;
  logic [VW-1:0] v_wd;

  // Registers
  logic [1:0]    cmd_r, cmd_nxt;
  logic [KW-1:0] key_r, key_nxt, lastk_r, lastk_nxt;
  logic [VW-1:0] val_r, val_nxt, lastv_r, lastv_nxt;
  logic [IW-1:0] home_r, home_nxt, b_r, b_nxt, e_r, e_nxt, entc_r, entc_nxt;
  logic [IW-1:0] idx_r, idx_nxt, hent_r, hent_nxt, clear_r, clear_nxt;
  logic [IW-1:0] fp_r, fp_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, pred_r, pred_nxt;
  logic [LW-1:0] linkb_r, linkb_nxt, linkc_r, linkc_nxt, hlink_r, hlink_nxt;
  logic          evict_r, evict_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [chm_pkg::CAPACITY-1:0] used_r, used_nxt;
  logic          res_found_r, res_found_nxt;
  logic [VW-1:0] res_val_r, res_val_nxt;
  logic [1:0]    res_status_r, res_status_nxt;

  logic [IW-1:0] last;
  logic [IW-1:0] other;
  logic [IW-1:0] tgt;

  assign last  = live_r[IW-1:0] - IW'(1);
  assign other = chm_pkg::home_of(key_rd_r);
  assign tgt   = evict_r ? home_r : fp_r;

  always_comb begin
    stat.cmd          = cmd_r;
    stat.live_zero    = (live_r == '0);
    stat.full         = (live_r == CW'(chm_pkg::CAPACITY));
    stat.cur_ok       = !cur_r[IW] && used_r[cur_r[IW-1:0]];
    stat.key_eq       = (key_rd_r == key_r);
    stat.h_used       = used_r[home_r];
    stat.fp_stop      = !(used_r[fp_r] && fp_r != '0);
    stat.evict        = evict_r;
    stat.walk_stop    = evict_r ? (link_rd_r == {1'b0, home_r}) : link_rd_r[IW];
    stat.gone_is_last = (e_r == last);
    stat.ent_is_last  = (ent_rd_r == last);
    stat.pred_valid   = !pred_r[IW];
    stat.linkb_valid  = !linkb_r[IW];
  end

  always_comb begin
    cmd_nxt = cmd_r; key_nxt = key_r; val_nxt = val_r;
    lastk_nxt = lastk_r; lastv_nxt = lastv_r;
    home_nxt = home_r; b_nxt = b_r; e_nxt = e_r; entc_nxt = entc_r;
    idx_nxt = idx_r; hent_nxt = hent_r; clear_nxt = clear_r; fp_nxt = fp_r;
    cur_nxt = cur_r; prev_nxt = prev_r; pred_nxt = pred_r;
    linkb_nxt = linkb_r; linkc_nxt = linkc_r; hlink_nxt = hlink_r;
    evict_nxt = evict_r; live_nxt = live_r; used_nxt = used_r;
    res_found_nxt = res_found_r; res_val_nxt = res_val_r;
    res_status_nxt = res_status_r;
    bk_re = 1'b0; be_we = 1'b0; lk_we = 1'b0;
    k_re = 1'b0; k_we = 1'b0; v_re = 1'b0; v_we = 1'b0;
    bk_ra = '0; be_wa = '0; lk_wa = '0; k_ra = '0; k_wa = '0; v_ra = '0; v_wa = '0;
    be_wd = '0; lk_wd = '0; k_wd = '0; v_wd = '0;
    case (uop)
      chm_pkg::U_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_cmd;
          key_nxt        = in_key;
          val_nxt        = in_value;
          home_nxt       = chm_pkg::home_of(in_key);
          cur_nxt        = {1'b0, chm_pkg::home_of(in_key)};
          prev_nxt       = chm_pkg::END_LINK;
          res_found_nxt  = 1'b0;
          res_val_nxt    = '0;
          res_status_nxt = chm_pkg::ST_OK;
        end
      end
      chm_pkg::U_F_RD: begin
        bk_re = 1'b1;
        bk_ra = cur_r[IW-1:0];
      end
      chm_pkg::U_F_EN: begin
        entc_nxt  = ent_rd_r;
        linkc_nxt = link_rd_r;
        k_re      = 1'b1;
        k_ra      = ent_rd_r;
      end
      chm_pkg::U_F_KEY: begin
        if (key_rd_r == key_r) begin
          b_nxt         = cur_r[IW-1:0];
          pred_nxt      = prev_r;
          e_nxt         = entc_r;
          linkb_nxt     = linkc_r;
          res_found_nxt = 1'b1;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = linkc_r;
        end
      end
      chm_pkg::U_L_RD: begin
        v_re = 1'b1;
        v_ra = e_r;
      end
      chm_pkg::U_L_VAL: res_val_nxt = val_rd_r;
      chm_pkg::U_S_WR: begin
        v_we        = 1'b1;
        v_wa        = e_r;
        v_wd        = val_r;
        res_val_nxt = val_r;
      end
      chm_pkg::U_NF: begin
        if (cmd_r == chm_pkg::CMD_SET) begin
          if (live_r == CW'(chm_pkg::CAPACITY)) begin
            res_status_nxt = chm_pkg::ST_FULL;
          end else begin
            k_we        = 1'b1;
            k_wa        = live_r[IW-1:0];
            k_wd        = key_r;
            v_we        = 1'b1;
            v_wa        = live_r[IW-1:0];
            v_wd        = val_r;
            idx_nxt     = live_r[IW-1:0];
            live_nxt    = live_r + CW'(1);
            res_val_nxt = val_r;
          end
        end else begin
          res_status_nxt = chm_pkg::ST_MISS;
        end
      end
      chm_pkg::U_P_HOME: begin
        if (!used_r[home_r]) begin
          used_nxt[home_r] = 1'b1;
          be_we = 1'b1; be_wa = home_r; be_wd = idx_r;
          lk_we = 1'b1; lk_wa = home_r; lk_wd = chm_pkg::END_LINK;
        end else begin
          bk_re = 1'b1;
          bk_ra = home_r;
        end
      end
      chm_pkg::U_P_FP: begin
        if (used_r[fp_r] && fp_r != '0) fp_nxt = fp_r - IW'(1);
      end
      chm_pkg::U_P_HK: begin
        hent_nxt  = ent_rd_r;
        hlink_nxt = link_rd_r;
        k_re      = 1'b1;
        k_ra      = ent_rd_r;
      end
      chm_pkg::U_P_OTH: begin
        evict_nxt = (other != home_r);
        cur_nxt   = (other != home_r) ? {1'b0, other} : {1'b0, home_r};
      end
      chm_pkg::U_W_RD: begin
        bk_re = 1'b1;
        bk_ra = cur_r[IW-1:0];
      end
      chm_pkg::U_W_CHK: begin
        if (!stat.walk_stop) cur_nxt = link_rd_r;
      end
      chm_pkg::U_P_LINK: begin
        lk_we = 1'b1; lk_wa = cur_r[IW-1:0]; lk_wd = {1'b0, fp_r};
      end
      chm_pkg::U_P_MOVE: begin
        used_nxt[fp_r] = 1'b1;
        be_we = 1'b1; be_wa = fp_r; be_wd = hent_r;
        lk_we = 1'b1; lk_wa = fp_r; lk_wd = hlink_r;
      end
      chm_pkg::U_P_FILL: begin
        used_nxt[tgt] = 1'b1;
        be_we = 1'b1; be_wa = tgt; be_wd = idx_r;
        lk_we = 1'b1; lk_wa = tgt; lk_wd = chm_pkg::END_LINK;
      end
      chm_pkg::U_R_START: begin
        k_re = 1'b1; k_ra = last;
        v_re = 1'b1; v_ra = last;
      end
      chm_pkg::U_R_LK: begin
        cur_nxt   = {1'b0, other};
        lastk_nxt = key_rd_r;
        lastv_nxt = val_rd_r;
      end
      chm_pkg::U_R_RD: begin
        bk_re = 1'b1;
        bk_ra = cur_r[IW-1:0];
      end
      chm_pkg::U_R_CHK: begin
        if (ent_rd_r == last) begin
          be_we = 1'b1; be_wa = cur_r[IW-1:0]; be_wd = e_r;
          k_we  = 1'b1; k_wa = e_r; k_wd = lastk_r;
          v_we  = 1'b1; v_wa = e_r; v_wd = lastv_r;
        end else begin
          cur_nxt = link_rd_r;
        end
      end
      chm_pkg::U_R_UNLINK: begin
        live_nxt = live_r - CW'(1);
        if (!pred_r[IW]) begin
          lk_we = 1'b1; lk_wa = pred_r[IW-1:0]; lk_wd = linkb_r;
          clear_nxt = b_r;
        end else if (!linkb_r[IW]) begin
          bk_re = 1'b1;
          bk_ra = linkb_r[IW-1:0];
          clear_nxt = linkb_r[IW-1:0];
        end else begin
          clear_nxt = b_r;
        end
      end
      chm_pkg::U_R_COPY: begin
        used_nxt[b_r] = used_r[clear_r];
        be_we = 1'b1; be_wa = b_r; be_wd = ent_rd_r;
        lk_we = 1'b1; lk_wa = b_r; lk_wd = link_rd_r;
      end
      chm_pkg::U_R_CLEAR: begin
        used_nxt[clear_r] = 1'b0;
        if (clear_r > fp_r) fp_nxt = clear_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= '0;
      fp_r    <= IW'(chm_pkg::CAPACITY - 1);
      used_r  <= '0;
      evict_r <= 1'b0;
    end else begin
      live_r  <= live_nxt;
      fp_r    <= fp_nxt;
      used_r  <= used_nxt;
      evict_r <= evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; key_r <= key_nxt; val_r <= val_nxt;
    lastk_r <= lastk_nxt; lastv_r <= lastv_nxt;
    home_r <= home_nxt; b_r <= b_nxt; e_r <= e_nxt; entc_r <= entc_nxt;
    idx_r <= idx_nxt; hent_r <= hent_nxt; clear_r <= clear_nxt;
    cur_r <= cur_nxt; prev_r <= prev_nxt; pred_r <= pred_nxt;
    linkb_r <= linkb_nxt; linkc_r <= linkc_nxt; hlink_r <= hlink_nxt;
    res_found_r <= res_found_nxt; res_val_r <= res_val_nxt;
    res_status_r <= res_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (be_we) bent_mem[be_wa] <= be_wd;
    if (lk_we) blink_mem[lk_wa] <= lk_wd;
    if (bk_re) begin
      ent_rd_r  <= bent_mem[bk_ra];
      link_rd_r <= blink_mem[bk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (k_we) key_mem[k_wa] <= k_wd;
    if (k_re) key_rd_r <= key_mem[k_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) val_mem[v_wa] <= v_wd;
    if (v_re) val_rd_r <= val_mem[v_ra];
  end

  assign res_found  = res_found_r;
  assign res_value  = res_val_r;
  assign res_status = res_status_r;
  assign res_count  = live_r;

`ifndef SYNTH
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(chm_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_live_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(live_r) |-> (live_r == $past(live_r) + CW'(1) ||
                          live_r + CW'(1) == $past(live_r)))
    else $error("entry count moved by more than one");

  a_fill_free: assert property (@(posedge clk) disable iff (!rst_n)
    (uop == chm_pkg::U_P_MOVE || (uop == chm_pkg::U_P_FILL && !evict_r))
      |-> !used_r[fp_r])
    else $error("free pointer lands on an occupied bucket");
`endif

endmodule

>>> rtl/coalesced_hash_map_engine.sv
// Top level of the coalesced hash map engine: sequencer, datapath and the
// result register. Depends on chm_pkg, chm_ctrl and chm_datapath.
//
// One command (lookup, set, remove) is in flight at a time. in_ready is high
// only while the sequencer is idle. The result register lets the next command
// start while an earlier result still waits on out_ready. Reads are of
// single-port bucket or entry memories with registered data, so the time
// per command follows the chains walked. Each command passes through idle
// at its input transfer, dispatch and result loading. The key search reads
// the bucket, the entry and its key for each occupied bucket compared. After
// a hit, a lookup reads the value and a set writes it. A new key fills its
// home bucket when that is free; otherwise it steps the free pointer, walks
// the chain and links in the free bucket, moving a foreign bucket out of the
// home when there is one. A remove moves the last entry into the freed slot
// when the removed entry is not last, walking the last entry's home chain,
// and pulls the next bucket into the home when needed. Bucket occupancy sits
// in flip-flops cleared by reset, so no clearing pass is needed.
module coalesced_hash_map_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic [chm_pkg::KEY_BITS-1:0]    in_key,
  input  logic [chm_pkg::VALUE_BITS-1:0]  in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [chm_pkg::VALUE_BITS-1:0]  out_read_value,
  output logic [1:0]                      out_status,
  output logic [chm_pkg::CNT_W-1:0]       out_entry_count
);

  chm_pkg::uop_t     uop;
  chm_pkg::dp_stat_t stat;
  logic              out_free;
  logic              res_found;
  logic [chm_pkg::VALUE_BITS-1:0] res_value;
  logic [1:0]        res_status;
  logic [chm_pkg::CNT_W-1:0] res_count;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r;
  logic [chm_pkg::VALUE_BITS-1:0] out_value_r;
  logic [1:0]        out_status_r;
  logic [chm_pkg::CNT_W-1:0] out_count_r;
  logic              load;

  // Result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_ready;
  assign load     = (uop == chm_pkg::U_RES) && out_free;

  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ready),
    .uop      (uop)
  );

  chm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .uop        (uop),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .in_value   (in_value),
    .stat       (stat),
    .res_found  (res_found),
    .res_value  (res_value),
    .res_status (res_status),
    .res_count  (res_count)
  );

  // Hold the result until its transfer, load a new one when free.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_found_r  <= res_found;
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_count_r  <= res_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_read_value  = out_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule
